// ===== design/kca_pkg.sv =====
// Shared types, constants and the fixed key table for the keypad click/autorepeat block.
// No dependencies; imported by kca_scan and keypad_click_autorepeat.
package kca_pkg;

   localparam int TABLE_SIZE  = 12;
   localparam int NUM_KEYS    = 12;
   localparam int ACTIVE_KEYS = (NUM_KEYS < TABLE_SIZE) ? NUM_KEYS : TABLE_SIZE;
   localparam int KEY_W       = 4;

   localparam logic [15:0] FIRST_DELAY_RST  = 16'd500;
   localparam logic [15:0] REPEAT_DELAY_RST = 16'd175;

   // configuration register indexes
   localparam logic CSR_FIRST_DELAY  = 1'b0;
   localparam logic CSR_REPEAT_DELAY = 1'b1;

   typedef logic [TABLE_SIZE-1:0] key_vec_type;

   typedef struct packed {
      logic [KEY_W-1:0] pressed;   // first key held now, 0 none
      logic [KEY_W-1:0] clicked;   // first key that went down, 0 none
      key_vec_type      held_now;  // per-entry held flags for this scan
   } scan_type;

   function automatic logic [1:0] key_group(input int idx);
      logic [1:0] grp;
      case (idx)
         0, 1, 2, 3: grp = 2'd0;
         4, 5:       grp = 2'd1;
         default:    grp = 2'd2;
      endcase
      return grp;
   endfunction

   function automatic logic [31:0] key_mask(input int idx);
      logic [31:0] m;
      case (idx)
         0:       m = 32'h0000_0008;
         1:       m = 32'h0000_0004;
         2:       m = 32'h0000_0001;
         3:       m = 32'h0000_0002;
         4:       m = 32'h0000_4000;
         5:       m = 32'h0000_0800;
         6:       m = 32'h0000_1001;
         7:       m = 32'h0000_0001;
         8:       m = 32'h0000_4000;
         9:       m = 32'h0000_2000;
         10:      m = 32'h0000_0040;
         default: m = 32'h0000_0040;
      endcase
      return m;
   endfunction

   // held flags of all table entries for one scan (active low words)
   function automatic key_vec_type held_keys(input logic [31:0] g0,
                                             input logic [31:0] g1,
                                             input logic [15:0] g2);
      key_vec_type v;
      logic [31:0] w;
      v = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         case (key_group(i))
            2'd0:    w = g0;
            2'd1:    w = g1;
            default: w = {16'h0000, g2};
         endcase
         v[i] = ((w & key_mask(i)) == 32'h0) && (i < ACTIVE_KEYS);
      end
      return v;
   endfunction

   // lowest set entry as entry+1, 0 when none
   function automatic logic [KEY_W-1:0] first_key(input key_vec_type v);
      logic [KEY_W-1:0] k;
      k = '0;
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
         if (v[i]) k = KEY_W'(i + 1);
      end
      return k;
   endfunction

endpackage

// ===== design/keypad_click_autorepeat.sv =====
// Keypad scanner top level: click detection and autorepeat on a stream interface.
// Input reg, then result reg, with the key match and one 32-bit tick subtract between them.
// Throughput: one scan per cycle unless rsp_tready holds the result reg (rsp_tvalid is its valid).
// Reset (synchronous, active high): previous scan, repeat key, event tick and repeat flag
// clear to zero; first_delay returns to 500 and repeat_delay to 175; no transaction pending.
// Depends on kca_pkg and kca_scan.
module keypad_click_autorepeat import kca_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // group_zero_bits, group_one_bits, group_two_bits, now_tick
   input  logic         req_tuser,  // clear_repeat
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // auto_key, first_pressed
   output logic         rsp_tuser,  // is_repeat
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   logic [15:0] first_delay_ff, first_delay_in;
   logic [15:0] repeat_delay_ff, repeat_delay_in;

   logic         s1_valid_ff, s1_valid_in;
   logic [111:0] s1_data_ff;
   logic         s1_clear_ff;

   logic             out_valid_ff, out_valid_in;
   logic [KEY_W-1:0] out_auto_ff, out_auto_in;
   logic [KEY_W-1:0] out_first_ff, out_first_in;
   logic             out_rep_ff, out_rep_in;

   logic [31:0]      prev_g0_ff, prev_g0_in;
   logic [31:0]      prev_g1_ff, prev_g1_in;
   logic [15:0]      prev_g2_ff, prev_g2_in;
   logic [KEY_W-1:0] repeat_key_ff, repeat_key_in;
   logic [31:0]      last_tick_ff, last_tick_in;
   logic             repeating_ff, repeating_in;

   logic        out_adv;
   logic        work;
   logic        req_take;
   scan_type    scan;
   logic [31:0] cur_g0, cur_g1, now;
   logic [15:0] cur_g2;
   logic [KEY_W-1:0] rk;
   logic [KEY_W-1:0] rk_idx;
   logic [31:0] diff;
   logic [15:0] limit;

   assign cur_g0 = s1_data_ff[31:0];
   assign cur_g1 = s1_data_ff[63:32];
   assign cur_g2 = s1_data_ff[79:64];
   assign now    = s1_data_ff[111:80];

   assign out_adv    = !out_valid_ff || rsp_tready;
   assign work       = s1_valid_ff && out_adv;
   assign req_tready = !s1_valid_ff || out_adv;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_first_ff, out_auto_ff};
   assign rsp_tuser  = out_rep_ff;

   kca_scan u_scan (
      .cur_g0 (cur_g0),
      .cur_g1 (cur_g1),
      .cur_g2 (cur_g2),
      .old_g0 (prev_g0_ff),
      .old_g1 (prev_g1_ff),
      .old_g2 (prev_g2_ff),
      .scan   (scan)
   );

   always_comb begin
      first_delay_in  = first_delay_ff;
      repeat_delay_in = repeat_delay_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_DELAY:  first_delay_in  = csr_wdata;
            CSR_REPEAT_DELAY: repeat_delay_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (work ? 1'b0 : s1_valid_ff);
      out_valid_in = work ? 1'b1 : (out_adv ? 1'b0 : out_valid_ff);
   end

   // step logic, applied when the stage-one scan moves to the result register
   always_comb begin
      rk     = s1_clear_ff ? '0 : repeat_key_ff;
      rk_idx = rk - KEY_W'(1);
      diff   = now - last_tick_ff;
      limit  = repeating_ff ? repeat_delay_ff : first_delay_ff;

      prev_g0_in    = prev_g0_ff;
      prev_g1_in    = prev_g1_ff;
      prev_g2_in    = prev_g2_ff;
      repeat_key_in = repeat_key_ff;
      last_tick_in  = last_tick_ff;
      repeating_in  = repeating_ff;
      out_auto_in   = out_auto_ff;
      out_first_in  = out_first_ff;
      out_rep_in    = out_rep_ff;

      if (work) begin
         prev_g0_in    = cur_g0;
         prev_g1_in    = cur_g1;
         prev_g2_in    = cur_g2;
         repeat_key_in = rk;
         out_auto_in   = '0;
         out_rep_in    = 1'b0;
         out_first_in  = scan.pressed;
         if (scan.clicked != '0) begin
            repeat_key_in = scan.clicked;
            repeating_in  = 1'b0;
            last_tick_in  = now;
            out_auto_in   = scan.clicked;
         end else if (rk != '0 && rk <= KEY_W'(ACTIVE_KEYS) && scan.held_now[rk_idx]) begin
            // wrapped difference read as signed; negative never repeats
            if (!diff[31] && diff > {16'h0000, limit}) begin
               repeating_in = 1'b1;
               last_tick_in = now;
               out_auto_in  = rk;
               out_rep_in   = 1'b1;
            end
         end else begin
            repeat_key_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff  <= FIRST_DELAY_RST;
         repeat_delay_ff <= REPEAT_DELAY_RST;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         prev_g0_ff      <= '0;
         prev_g1_ff      <= '0;
         prev_g2_ff      <= '0;
         repeat_key_ff   <= '0;
         last_tick_ff    <= '0;
         repeating_ff    <= 1'b0;
      end else begin
         first_delay_ff  <= first_delay_in;
         repeat_delay_ff <= repeat_delay_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
         prev_g0_ff      <= prev_g0_in;
         prev_g1_ff      <= prev_g1_in;
         prev_g2_ff      <= prev_g2_in;
         repeat_key_ff   <= repeat_key_in;
         last_tick_ff    <= last_tick_in;
         repeating_ff    <= repeating_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff  <= req_tdata;
         s1_clear_ff <= req_tuser;
      end
      out_auto_ff  <= out_auto_in;
      out_first_ff <= out_first_in;
      out_rep_ff   <= out_rep_in;
   end

endmodule

// ===== design/kca_scan.sv =====
// Key table match: held, first-pressed and clicked keys for one scan.
// Depends on kca_pkg for the table and the scan_type struct.
module kca_scan import kca_pkg::*; (
   input  logic [31:0] cur_g0,
   input  logic [31:0] cur_g1,
   input  logic [15:0] cur_g2,
   input  logic [31:0] old_g0,
   input  logic [31:0] old_g1,
   input  logic [15:0] old_g2,
   output scan_type    scan
);

   key_vec_type held_cur;
   key_vec_type held_old;

   always_comb begin
      held_cur      = held_keys(cur_g0, cur_g1, cur_g2);
      held_old      = held_keys(old_g0, old_g1, old_g2);
      scan.held_now = held_cur;
      scan.pressed  = first_key(held_cur);
      // click: not fully down last scan, fully down now
      scan.clicked  = first_key(held_cur & ~held_old);
   end

endmodule
